// ===== hw/rtl/prime_sieve_center_cut_defines.svh =====
// Assertion macros for the checker file of the prime sieve block.
`ifndef PRIME_SIEVE_CENTER_CUT_DEFINES_SVH
`define PRIME_SIEVE_CENTER_CUT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define PSC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("psc check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define PSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("psc check failed");

`endif

// ===== hw/rtl/psc_pkg.sv =====
// Package for the prime sieve block: sizes, token and control types.
package psc_pkg;

  localparam int MAX_N      = 256;
  localparam int LIST_DEPTH = 64;

  localparam int VAL_W   = 9;
  localparam int CUT_W   = 8;
  localparam int MUL_W   = VAL_W + 1;
  localparam int LIST_AW = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);

  // floor(sqrt(n)); at least as many cells as primes up to sqrt(MAX_N)
  function automatic int isqrt(input int n);
    int r;
    r = 1;
    while ((r + 1) * (r + 1) <= n) r = r + 1;
    return r;
  endfunction

  localparam int NUM_CELLS = isqrt(MAX_N);

  // held: some cell already took this prime, so later cells pass it on
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             comp;
    logic             held;
    logic [VAL_W-1:0] value;
  } token_t;

  typedef struct packed {
    logic clear;
  } list_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } list_stat_t;

endpackage

// ===== hw/rtl/psc_if.sv =====
// Stream interfaces for the query and result channels.
interface psc_in_if;
  logic                   valid;
  logic                   ready;
  logic [psc_pkg::VAL_W-1:0] limit_n;
  logic [psc_pkg::CUT_W-1:0] cut_count;

  modport source (output valid, output limit_n, output cut_count, input ready);
  modport sink   (input valid, input limit_n, input cut_count, output ready);
endinterface

interface psc_out_if;
  logic                   valid;
  logic                   ready;
  logic [psc_pkg::VAL_W-1:0] prime_value;
  logic                   last_of_run;
  logic                   empty_selection;

  modport source (output valid, output prime_value, output last_of_run,
                  output empty_selection, input ready);
  modport sink   (input valid, input prime_value, input last_of_run,
                  input empty_selection, output ready);
endinterface

// ===== hw/rtl/psc_cell.sv =====
// Sieve cell: holds one prime and its next multiple, marks matching tokens.
module psc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  psc_pkg::token_t tok_in,
  output psc_pkg::token_t tok_out
);
  import psc_pkg::*;

  logic             full;
  logic [VAL_W-1:0] p;
  logic [MUL_W-1:0] m;

  logic             full_next;
  logic [VAL_W-1:0] p_next;
  logic [MUL_W-1:0] m_next;
  token_t           tok_next;

  // every integer passes in order, so m always sits at the next multiple
  always_comb begin
    tok_next  = tok_in;
    full_next = full;
    p_next    = p;
    m_next    = m;
    if (tok_in.valid) begin
      if (!full) begin
        if (!tok_in.comp && !tok_in.held && (tok_in.value >= VAL_W'(2))) begin
          full_next     = 1'b1;
          p_next        = tok_in.value;
          m_next        = {tok_in.value, 1'b0};
          tok_next.held = 1'b1;
        end
      end else if ({1'b0, tok_in.value} == m) begin
        tok_next.comp = 1'b1;
        m_next        = m + MUL_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      full    <= clear ? 1'b0 : full_next;
      tok_out <= tok_next;
    end
    p <= p_next;
    m <= m_next;
  end

endmodule

// ===== hw/rtl/psc_list.sv =====
// Prime list store: collects unmarked tokens from the chain, serves reads.
module psc_list (
  input  logic                         clk,
  input  logic                         rst,
  input  psc_pkg::list_ctrl_t          ctrl,
  input  psc_pkg::token_t              tok,
  input  logic [psc_pkg::LIST_AW-1:0]  rd_addr,
  output logic [psc_pkg::VAL_W-1:0]    rd_data,
  output psc_pkg::list_stat_t          stat
);
  import psc_pkg::*;

  logic [VAL_W-1:0] mem [LIST_DEPTH];
  logic [CNT_W-1:0] count;
  logic             done;
  logic             wr_en;

  assign wr_en = tok.valid && !tok.comp && (count < CNT_W'(LIST_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[LIST_AW-1:0]] <= tok.value;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (ctrl.clear) count <= '0;
      else if (wr_en) count <= count + CNT_W'(1);
      done <= tok.valid && tok.last;
    end
  end

  assign stat.done  = done;
  assign stat.count = count;

endmodule

// ===== hw/rtl/prime_sieve_center_cut.sv =====
// Top level: query sequencer, sieve cell chain, list store and result stage.
//
// Usage: a query item on the query channel carries limit_n and cut_count.
// The block streams 0..n (n saturated to MAX_N) through a row of sieve cells,
// one integer per cycle; unmarked integers (1 included) land in the prime
// list. It then picks the centered cut and sends the selected primes on the
// result channel in ascending order, last_of_run on the final one. An empty
// selection gives one result with empty_selection and last_of_run set.
// Steps: the feed of 0..n, the drain of the cell chain, the selection of the
// cut, then a list read and a load into the result register per result.
// One query is worked at a time: query ready is high only while idle, and
// idle returns once the last result of a query sits in the result register.
// Throughput is set by the feed through the cell chain plus the list walk.
// Reset (rst, synchronous) empties the cells, the result register and the
// sequencer. A stalled receiver holds the result register and the list walk
// waits on it; nothing is dropped.
module prime_sieve_center_cut (
  input  logic             clk,
  input  logic             rst,
  psc_in_if.sink           query,
  psc_out_if.source        result
);
  import psc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SIEVE  = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_SELECT = 7'b0001000,
    S_READ   = 7'b0010000,
    S_LOAD   = 7'b0100000,
    S_EMPTY  = 7'b1000000
  } state_t;

  state_t           state;
  logic [VAL_W-1:0] n_lim;
  logic [CUT_W-1:0] cut;
  logic [VAL_W-1:0] x;
  logic [CNT_W-1:0] sel_start;
  logic [CNT_W-1:0] sel_count;
  logic [CNT_W-1:0] k;

  logic             out_valid;
  logic [VAL_W-1:0] out_value;
  logic             out_last;
  logic             out_empty;

  logic             accept;
  logic             slot_free;
  logic             load_prime;
  logic             load_empty;
  logic [CNT_W-1:0] rd_sum;
  logic [VAL_W-1:0] rd_data;
  list_ctrl_t       ctrl;
  list_stat_t       stat;
  token_t           chain [NUM_CELLS+1];

  // centered cut, all in 10-bit arithmetic
  logic [9:0] jw, cw, tc;
  logic [CNT_W-1:0] start_calc, count_calc;

  assign accept      = query.valid && query.ready;
  assign query.ready = (state == S_IDLE);
  assign slot_free   = !out_valid || result.ready;
  assign load_prime  = (state == S_LOAD) && slot_free;
  assign load_empty  = (state == S_EMPTY) && slot_free;
  assign ctrl.clear  = accept;
  assign rd_sum      = sel_start + k;

  always_comb begin
    jw = 10'(stat.count);
    cw = 10'(cut);
    tc = cw << 1;
    if (!jw[0] && (tc < jw)) begin
      start_calc = CNT_W'((jw - tc) >> 1);
      count_calc = CNT_W'(tc);
    end else if (jw[0] && (cw != 10'd0) && ((tc - 10'd1) < jw)) begin
      start_calc = CNT_W'((jw >> 1) + 10'd1 - cw);
      count_calc = CNT_W'(tc - 10'd1);
    end else if (jw[0] && (cw == 10'd0)) begin
      start_calc = '0;
      count_calc = '0;
    end else begin
      start_calc = '0;
      count_calc = stat.count;
    end
  end

  // integer source feeding the cell chain
  assign chain[0] = '{valid: (state == S_SIEVE), last: (x == n_lim), comp: (x == '0),
                      held: 1'b0, value: x};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    psc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (ctrl.clear),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  psc_list u_list (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .tok     (chain[NUM_CELLS]),
    .rd_addr (rd_sum[LIST_AW-1:0]),
    .rd_data (rd_data),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_SIEVE;
        end
        S_SIEVE: begin
          if (x == n_lim) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (stat.done) state <= S_SELECT;
        end
        S_SELECT: begin
          state <= (count_calc == '0) ? S_EMPTY : S_READ;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) state <= (k + CNT_W'(1) == sel_count) ? S_IDLE : S_READ;
        end
        S_EMPTY: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_lim <= (query.limit_n > VAL_W'(MAX_N)) ? VAL_W'(MAX_N) : query.limit_n;
      cut   <= query.cut_count;
      x     <= '0;
    end else if (state == S_SIEVE && x != n_lim) begin
      x <= x + VAL_W'(1);
    end
    if (state == S_SELECT) begin
      sel_start <= start_calc;
      sel_count <= count_calc;
      k         <= '0;
    end else if (load_prime) begin
      k <= k + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_prime || load_empty) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (load_prime) begin
      out_value <= rd_data;
      out_last  <= (k + CNT_W'(1) == sel_count);
      out_empty <= 1'b0;
    end else if (load_empty) begin
      out_value <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  assign result.valid           = out_valid;
  assign result.prime_value     = out_value;
  assign result.last_of_run     = out_last;
  assign result.empty_selection = out_empty;

endmodule

// ===== hw/rtl/psc_checker.sv =====
// Port-level checker for the prime sieve block, with its bind.
`include "prime_sieve_center_cut_defines.svh"

module psc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      q_valid,
  input logic                      q_ready,
  input logic                      r_valid,
  input logic                      r_ready,
  input logic [psc_pkg::VAL_W-1:0] r_value,
  input logic                      r_last,
  input logic                      r_empty
);

  // a stalled result holds
  `PSC_ASSERT_NEXT(a_hold, r_valid && !r_ready, r_valid && $stable(r_value) && $stable(r_last) && $stable(r_empty))
  // an empty selection is always the only and final item of its query
  `PSC_ASSERT_NOW(a_empty_last, r_valid && r_empty, r_last)
  // a selected entry is 1 or a prime, never zero
  `PSC_ASSERT_NOW(a_nonzero, r_valid && !r_empty, r_value != '0)
  // one query at a time: busy right after accepting
  `PSC_ASSERT_NEXT(a_busy, q_valid && q_ready, !q_ready)

endmodule

bind prime_sieve_center_cut psc_checker u_psc_checker (
  .clk     (clk),
  .rst     (rst),
  .q_valid (query.valid),
  .q_ready (query.ready),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_value (result.prime_value),
  .r_last  (result.last_of_run),
  .r_empty (result.empty_selection)
);

// ===== tb/sv/prime_sieve_center_cut_tb.sv =====
// Self-checking testbench for the prime sieve centered-cut block.
module prime_sieve_center_cut_tb;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 400;
  localparam int NUM_ROWS    = 22;
  localparam int RAND_ITEMS  = 26;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             empty;
  } prime_item_t;

  // directed query; when typed is set, the single result is given in the row
  typedef struct packed {
    logic [VAL_W-1:0] n;
    logic [CUT_W-1:0] c;
    logic             typed;
    logic [VAL_W-1:0] tv;
    logic             te;
  } query_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psc_in_if  query_ch ();
  psc_out_if result_ch ();

  prime_sieve_center_cut DUT (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  always #1 clk = ~clk;

  prime_item_t pending_primes[$];
  query_row_t  directed_rows[NUM_ROWS];
  int          mismatches  = 0;
  int          cycles      = 0;
  int          send_idle   = 38;
  int          recv_stall  = 46;

  // Sieve over 0..n (1 counts as prime), then queue the centered cut.
  function automatic void predict_center_cut(input logic [VAL_W-1:0] n_in,
                                             input logic [CUT_W-1:0] c_in);
    bit               composite[0:MAX_N];
    logic [VAL_W-1:0] primes[0:LIST_DEPTH-1];
    int               n;
    int               c;
    int               j;
    int               start;
    int               count;
    n = int'(n_in);
    c = int'(c_in);
    if (n > MAX_N) n = MAX_N;
    for (int i = 0; i <= n; i++) composite[i] = 1'b0;
    composite[0] = 1'b1;
    for (int i = 2; i <= n; i++) begin
      if (!composite[i]) begin
        for (int m = 2 * i; m <= n; m += i) composite[m] = 1'b1;
      end
    end
    j = 0;
    for (int i = 0; i <= n; i++) begin
      if (!composite[i] && j < LIST_DEPTH) begin
        primes[j] = i[VAL_W-1:0];
        j++;
      end
    end
    if (j % 2 == 0 && 2 * c < j) begin
      start = (j - 2 * c) / 2;
      count = 2 * c;
    end else if (j % 2 != 0 && c >= 1 && 2 * c - 1 < j) begin
      start = j / 2 + 1 - c;
      count = 2 * c - 1;
    end else if (j % 2 != 0 && c == 0) begin
      start = 0;
      count = 0;
    end else begin
      start = 0;
      count = j;
    end
    if (count == 0) begin
      pending_primes.push_back('{value: '0, last: 1'b1, empty: 1'b1});
    end else begin
      for (int k = 0; k < count; k++)
        pending_primes.push_back('{value: primes[start + k], last: (k == count - 1),
                                   empty: 1'b0});
    end
  endfunction

  task automatic send_query(input logic [VAL_W-1:0] n, input logic [CUT_W-1:0] c);
    while ($urandom_range(0, 99) < send_idle) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid     <= 1'b1;
    query_ch.limit_n   <= n;
    query_ch.cut_count <= c;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_query();
    logic [VAL_W-1:0] n;
    logic [CUT_W-1:0] c;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      n = VAL_W'($urandom_range(MAX_N + 1, 511));
    else if (pick < 40) n = VAL_W'($urandom_range(0, 20));
    else                n = VAL_W'($urandom_range(0, MAX_N));
    if ($urandom_range(0, 99) < 10) c = CUT_W'($urandom_range(0, 255));
    else                            c = CUT_W'($urandom_range(0, 30));
    send_query(n, c);
    predict_center_cut(n, c);
  endtask

  // result side: random stall, compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    prime_item_t exp_item;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result item: prime_value=%0d last_of_run=%0b empty_selection=%0b",
               result_ch.prime_value, result_ch.last_of_run, result_ch.empty_selection);
        mismatches++;
      end else begin
        exp_item = pending_primes.pop_front();
        // prime_value carries no meaning on an empty selection
        if (!exp_item.empty && result_ch.prime_value !== exp_item.value) begin
          $error("prime_value: expected %0d, got %0d", exp_item.value, result_ch.prime_value);
          mismatches++;
        end
        if (result_ch.last_of_run !== exp_item.last) begin
          $error("last_of_run: expected %0b, got %0b", exp_item.last, result_ch.last_of_run);
          mismatches++;
        end
        if (result_ch.empty_selection !== exp_item.empty) begin
          $error("empty_selection: expected %0b, got %0b", exp_item.empty,
                 result_ch.empty_selection);
          mismatches++;
        end
      end
    end
    result_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    query_ch.valid     <= 1'b0;
    query_ch.limit_n   <= '0;
    query_ch.cut_count <= '0;

    //                 n    c    typed tv  te
    directed_rows = '{
      '{9'd0,   8'd0,   1'b1, 9'd0, 1'b1},  // empty list
      '{9'd0,   8'd255, 1'b1, 9'd0, 1'b1},
      '{9'd1,   8'd0,   1'b1, 9'd0, 1'b1},  // odd list, no cut
      '{9'd1,   8'd1,   1'b1, 9'd1, 1'b0},
      '{9'd2,   8'd0,   1'b1, 9'd0, 1'b1},  // even list, no cut
      '{9'd2,   8'd1,   1'b0, 9'd0, 1'b0},
      '{9'd3,   8'd1,   1'b1, 9'd2, 1'b0},
      '{9'd3,   8'd2,   1'b0, 9'd0, 1'b0},
      '{9'd4,   8'd1,   1'b0, 9'd0, 1'b0},
      '{9'd5,   8'd1,   1'b0, 9'd0, 1'b0},
      '{9'd256, 8'd0,   1'b1, 9'd0, 1'b1},
      '{9'd256, 8'd1,   1'b0, 9'd0, 1'b0},
      '{9'd256, 8'd27,  1'b0, 9'd0, 1'b0},  // widest proper cut
      '{9'd256, 8'd28,  1'b0, 9'd0, 1'b0},  // cut just covers the list
      '{9'd256, 8'd255, 1'b0, 9'd0, 1'b0},
      '{9'd257, 8'd5,   1'b0, 9'd0, 1'b0},  // limit saturates
      '{9'd511, 8'd170, 1'b0, 9'd0, 1'b0},
      '{9'd300, 8'd85,  1'b0, 9'd0, 1'b0},
      '{9'd255, 8'd3,   1'b0, 9'd0, 1'b0},
      '{9'd128, 8'd16,  1'b0, 9'd0, 1'b0},
      '{9'd100, 8'd64,  1'b0, 9'd0, 1'b0},
      '{9'd6,   8'd128, 1'b0, 9'd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_query(directed_rows[r].n, directed_rows[r].c);
      if (directed_rows[r].typed)
        pending_primes.push_back('{value: directed_rows[r].tv, last: 1'b1,
                                   empty: directed_rows[r].te});
      else
        predict_center_cut(directed_rows[r].n, directed_rows[r].c);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle  = 38;
          recv_stall = 46;
        end
        1: begin
          send_idle  = 46;
          recv_stall = 38;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
        end
      endcase
      for (int i = 0; i < RAND_ITEMS; i++) send_random_query();
    end

    query_ch.valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
